/* src/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Length forms, taken from the 7-bit length code
	localparam logic [1:0] LEN_FMT_7  = 2'd0;
	localparam logic [1:0] LEN_FMT_16 = 2'd1;
	localparam logic [1:0] LEN_FMT_64 = 2'd2;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// Header byte index of the last length byte for each form
	localparam logic [3:0] LEN_END_7  = 4'd1;
	localparam logic [3:0] LEN_END_16 = 4'd3;
	localparam logic [3:0] LEN_END_64 = 4'd9;

	localparam logic [3:0] KEY_BYTES = 4'd4;

	// Result kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam int DATA_BITS  = 81;
	localparam int TDATA_BITS = 88;

	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [7:0]  data;
		logic        frame_end;
	} res_t;

endpackage

/* src/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-wide WebSocket frame parser: header decode and payload unmasking.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)                         | tuser / tlast
//  s_axis   | in  | data_byte[7:0]                                    | -
//  m_axis   | out | fin, rsv[2:0], opcode[3:0], is_masked,            | result_kind /
//           |     | payload_length[63:0], data_out[7:0], zero pad     | frame_end
//
//  One byte is taken per clock while a held result does not stall the input;
//  a result reaches m_axis through the input register, then the result register.
//  The per-byte path is the 64-bit body count increment and its compare
//  against the frame length, sitting between the two registers.
//  Reset clears the parser to header byte 0 and empties both registers.
//  A stalled result holds the input register only when that byte also makes
//  a result; header bytes that make none still advance.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // data_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// fin, rsv[2:0], opcode[3:0], is_masked, payload_length[63:0], data_out[7:0]
	output logic [wsd_pkg::TDATA_BITS-1:0] m_axis_tdata,
	output logic                          m_axis_tuser,  // result_kind
	output logic                          m_axis_tlast   // frame_end
);
	import wsd_pkg::*;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register
	logic       out_valid_q;
	res_t       out_res_q;

	logic       res_valid;
	res_t       res;
	logic       step;
	logic       s_accept;

	// Advance the input stage unless its result would overwrite a held one
	assign step     = valid_s1 && (!res_valid || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	wsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_res_q <= res;
		end
	end

	// Pack the result word, first field lowest
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tlast  = out_res_q.frame_end;
	assign m_axis_tdata  = {{(TDATA_BITS-DATA_BITS){1'b0}},
		out_res_q.data, out_res_q.length, out_res_q.masked,
		out_res_q.opcode, out_res_q.rsv, out_res_q.fin};

	a_hdr_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.kind == KIND_HEADER) |-> out_res_q.data == 8'd0)
		else $error("header result carries payload data");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte lost");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("empty input stage not ready");

endmodule

/* src/wsd_core.sv */
// ----------------------------------------------------------------------------
// wsd_core
// Frame parsing state and per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module wsd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	output logic             res_valid,
	output wsd_pkg::res_t    res
);
	import wsd_pkg::*;

	logic        in_body_q,    in_body_d;
	logic [3:0]  hdr_idx_q,    hdr_idx_d;
	logic [1:0]  len_fmt_q,    len_fmt_d;
	logic        fin_q,        fin_d;
	logic [2:0]  rsv_q,        rsv_d;
	logic [3:0]  opcode_q,     opcode_d;
	logic        masked_q,     masked_d;
	logic [63:0] frame_len_q,  frame_len_d;
	logic [31:0] mask_key_q,   mask_key_d;
	logic [1:0]  key_pos_q,    key_pos_d;
	logic [63:0] body_cnt_q,   body_cnt_d;

	logic [7:0]  key_byte;
	logic [7:0]  data_d;
	logic        end_d;
	logic        kind_d;
	logic [3:0]  len_end;
	logic [1:0]  key_slot;
	logic        finish;

	always_comb begin
		case (key_pos_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
		case (len_fmt_q)
			LEN_FMT_16: len_end = LEN_END_16;
			LEN_FMT_64: len_end = LEN_END_64;
			default:    len_end = LEN_END_7;
		endcase
		key_slot = 2'(hdr_idx_q - len_end - 4'd1);
	end

	always_comb begin
		in_body_d   = in_body_q;
		hdr_idx_d   = hdr_idx_q;
		len_fmt_d   = len_fmt_q;
		fin_d       = fin_q;
		rsv_d       = rsv_q;
		opcode_d    = opcode_q;
		masked_d    = masked_q;
		frame_len_d = frame_len_q;
		mask_key_d  = mask_key_q;
		key_pos_d   = key_pos_q;
		body_cnt_d  = body_cnt_q;
		res_valid   = 1'b0;
		kind_d      = KIND_HEADER;
		data_d      = 8'd0;
		end_d       = 1'b0;
		finish      = 1'b0;

		if (in_body_q) begin
			data_d = data_byte;
			if (masked_q) begin
				data_d    = data_byte ^ key_byte;
				key_pos_d = key_pos_q + 2'd1;
			end
			body_cnt_d = body_cnt_q + 64'd1;
			end_d      = (body_cnt_d == frame_len_q);
			if (end_d) begin
				in_body_d = 1'b0;
				hdr_idx_d = 4'd0;
			end
			kind_d    = KIND_PAYLOAD;
			res_valid = 1'b1;
		end else if (hdr_idx_q == 4'd0) begin
			fin_d      = data_byte[7];
			rsv_d      = data_byte[6:4];
			opcode_d   = data_byte[3:0];
			len_fmt_d  = LEN_FMT_7;
			mask_key_d = 32'd0;
			key_pos_d  = 2'd0;
			hdr_idx_d  = 4'd1;
		end else if (hdr_idx_q == 4'd1) begin
			masked_d  = data_byte[7];
			hdr_idx_d = 4'd2;
			if (data_byte[6:0] == LEN_CODE_64) begin
				len_fmt_d   = LEN_FMT_64;
				frame_len_d = 64'd0;
			end else if (data_byte[6:0] == LEN_CODE_16) begin
				len_fmt_d   = LEN_FMT_16;
				frame_len_d = 64'd0;
			end else begin
				len_fmt_d   = LEN_FMT_7;
				frame_len_d = {57'd0, data_byte[6:0]};
				finish      = !data_byte[7];
			end
		end else if (hdr_idx_q <= len_end) begin
			frame_len_d = {frame_len_q[55:0], data_byte};
			hdr_idx_d   = hdr_idx_q + 4'd1;
			finish      = (hdr_idx_q == len_end) && !masked_q;
		end else if (masked_q && (hdr_idx_q < len_end + KEY_BYTES + 4'd1)) begin
			case (key_slot)
				2'd0:    mask_key_d[31:24] = data_byte;
				2'd1:    mask_key_d[23:16] = data_byte;
				2'd2:    mask_key_d[15:8]  = data_byte;
				default: mask_key_d[7:0]   = data_byte;
			endcase
			hdr_idx_d = hdr_idx_q + 4'd1;
			finish    = (hdr_idx_q == len_end + KEY_BYTES);
		end

		// Close the header: enter the body unless the frame is empty
		if (finish) begin
			hdr_idx_d = 4'd0;
			res_valid = 1'b1;
			if (frame_len_d != 64'd0) begin
				in_body_d  = 1'b1;
				body_cnt_d = 64'd0;
				key_pos_d  = 2'd0;
			end else begin
				end_d = 1'b1;
			end
		end
	end

	always_comb begin
		res.kind      = kind_d;
		res.fin       = fin_d;
		res.rsv       = rsv_d;
		res.opcode    = opcode_d;
		res.masked    = masked_d;
		res.length    = frame_len_d;
		res.data      = data_d;
		res.frame_end = end_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q   <= 1'b0;
			hdr_idx_q   <= 4'd0;
			len_fmt_q   <= LEN_FMT_7;
			fin_q       <= 1'b0;
			rsv_q       <= 3'd0;
			opcode_q    <= 4'd0;
			masked_q    <= 1'b0;
			frame_len_q <= 64'd0;
			mask_key_q  <= 32'd0;
			key_pos_q   <= 2'd0;
			body_cnt_q  <= 64'd0;
		end else if (step) begin
			in_body_q   <= in_body_d;
			hdr_idx_q   <= hdr_idx_d;
			len_fmt_q   <= len_fmt_d;
			fin_q       <= fin_d;
			rsv_q       <= rsv_d;
			opcode_q    <= opcode_d;
			masked_q    <= masked_d;
			frame_len_q <= frame_len_d;
			mask_key_q  <= mask_key_d;
			key_pos_q   <= key_pos_d;
			body_cnt_q  <= body_cnt_d;
		end
	end

	a_body_at_hdr0: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> hdr_idx_q == 4'd0)
		else $error("header index not zero in body");

	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> frame_len_q != 64'd0)
		else $error("body entered with zero length");

	a_unmasked_key: assert property (@(posedge clk) disable iff (!arst_n)
		(in_body_q && !masked_q) |-> key_pos_q == 2'd0)
		else $error("key position moved in unmasked body");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream test of the WebSocket frame deframer. Frames go in one byte per word.
// An in-bench decoder tracks the header and payload state and predicts every
// header event and unmasked payload byte. The result stream is checked word
// by word, in order, with both sides idling at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsd_pkg::*;

	// Decoder state plus the queue of results still to come from the block
	class deframe_tracker;
		logic        in_body;
		logic [3:0]  header_index;
		logic [1:0]  length_format;
		logic        cur_fin;
		logic [2:0]  cur_rsv;
		logic [3:0]  cur_opcode;
		logic        cur_masked;
		logic [63:0] frame_length;
		logic [31:0] mask_key;
		logic [1:0]  key_position;
		logic [63:0] body_count;
		res_t        pending_results[$];
		int          failures;

		function new();
			in_body = 1'b0;
			header_index = '0;
			length_format = LEN_FMT_7;
			cur_fin = 1'b0;
			cur_rsv = '0;
			cur_opcode = '0;
			cur_masked = 1'b0;
			frame_length = '0;
			mask_key = '0;
			key_position = '0;
			body_count = '0;
			failures = 0;
		endfunction

		function void queue_result(logic kind, logic [7:0] data, logic last);
			res_t r;
			r.kind = kind;
			r.fin = cur_fin;
			r.rsv = cur_rsv;
			r.opcode = cur_opcode;
			r.masked = cur_masked;
			r.length = frame_length;
			r.data = data;
			r.frame_end = last;
			pending_results.push_back(r);
		endfunction

		// Header done: a zero-length frame ends right here
		function void close_header();
			header_index = '0;
			if (frame_length != 64'd0) begin
				in_body = 1'b1;
				body_count = '0;
				key_position = '0;
				queue_result(KIND_HEADER, 8'h00, 1'b0);
			end else begin
				queue_result(KIND_HEADER, 8'h00, 1'b1);
			end
		endfunction

		// Advance the decoder by one accepted stream byte
		function void byte_taken(logic [7:0] b);
			logic [7:0] d;
			logic [3:0] idx;
			logic [3:0] len_end;
			logic [3:0] key_start;
			logic [6:0] code;
			if (in_body) begin
				d = b;
				if (cur_masked) begin
					d = b ^ mask_key[31 - 8 * key_position -: 8];
					key_position = key_position + 2'd1;
				end
				body_count = body_count + 64'd1;
				if (body_count == frame_length) begin
					in_body = 1'b0;
					header_index = '0;
					queue_result(KIND_PAYLOAD, d, 1'b1);
				end else begin
					queue_result(KIND_PAYLOAD, d, 1'b0);
				end
				return;
			end
			idx = header_index;
			if (idx == 4'd0) begin
				cur_fin = b[7];
				cur_rsv = b[6:4];
				cur_opcode = b[3:0];
				length_format = LEN_FMT_7;
				mask_key = '0;
				key_position = '0;
				header_index = 4'd1;
				return;
			end
			if (idx == 4'd1) begin
				code = b[6:0];
				cur_masked = b[7];
				if (code == LEN_CODE_64) begin
					length_format = LEN_FMT_64;
					frame_length = '0;
				end else if (code == LEN_CODE_16) begin
					length_format = LEN_FMT_16;
					frame_length = '0;
				end else begin
					length_format = LEN_FMT_7;
					frame_length = {57'd0, code};
					if (!cur_masked) begin
						close_header();
						return;
					end
				end
				header_index = 4'd2;
				return;
			end
			case (length_format)
				LEN_FMT_16: len_end = LEN_END_16;
				LEN_FMT_64: len_end = LEN_END_64;
				default:    len_end = LEN_END_7;
			endcase
			key_start = len_end + 4'd1;
			if (idx <= len_end) begin
				frame_length = {frame_length[55:0], b};
				if (idx == len_end && !cur_masked) begin
					close_header();
					return;
				end
				header_index = idx + 4'd1;
				return;
			end
			if (cur_masked && idx < key_start + KEY_BYTES) begin
				mask_key[31 - 8 * (idx - key_start) -: 8] = b;
				if (idx == key_start + KEY_BYTES - 4'd1) begin
					close_header();
					return;
				end
				header_index = idx + 4'd1;
			end
		endfunction

		function void result_seen(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result kind=%0b data=%02h end=%0b",
						$realtime, got.kind, got.data, got.frame_end);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.fin !== want.fin || got.rsv !== want.rsv ||
					got.opcode !== want.opcode || got.masked !== want.masked ||
					got.length !== want.length || got.data !== want.data ||
					got.frame_end !== want.frame_end) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: result mismatch", $realtime);
					$display("  expected kind=%0b fin=%0b rsv=%0d op=%0h msk=%0b len=%016h data=%02h end=%0b",
						want.kind, want.fin, want.rsv, want.opcode, want.masked, want.length,
						want.data, want.frame_end);
					$display("  actual   kind=%0b fin=%0b rsv=%0d op=%0h msk=%0b len=%016h data=%02h end=%0b",
						got.kind, got.fin, got.rsv, got.opcode, got.masked, got.length,
						got.data, got.frame_end);
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'h00;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	deframe_tracker tracker;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int words_sent = 0;

	always #10 clk = ~clk;

	websocket_frame_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata (s_tdata),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_tdata),
		.m_axis_tuser (m_tuser),
		.m_axis_tlast (m_tlast)
	);

	// Result side: check each accepted word, then pick the next stall
	always @(posedge clk) begin
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.fin = m_tdata[0];
			got.rsv = m_tdata[3:1];
			got.opcode = m_tdata[7:4];
			got.masked = m_tdata[8];
			got.length = m_tdata[72:9];
			got.data = m_tdata[80:73];
			got.frame_end = m_tlast;
			tracker.result_seen(got);
		end
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Offer one byte, idling first at random, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.byte_taken(b);
		words_sent++;
	endtask

	// Build one frame; body_bytes may fall short of len for the open-ended tail
	task automatic send_frame(input logic [7:0] b0, input logic masked,
			input logic [1:0] form, input logic [63:0] len, input logic [31:0] key,
			input int body_bytes);
		send_byte(b0);
		case (form)
			LEN_FMT_16: begin
				send_byte({masked, LEN_CODE_16});
				send_byte(len[15:8]);
				send_byte(len[7:0]);
			end
			LEN_FMT_64: begin
				send_byte({masked, LEN_CODE_64});
				for (int i = 7; i >= 0; i--)
					send_byte(len[8 * i +: 8]);
			end
			default: send_byte({masked, len[6:0]});
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		for (int i = 0; i < body_bytes; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_random_frame();
		logic [1:0]  form;
		logic [63:0] len;
		int          pick;
		form = 2'($urandom_range(0, 2));
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = (form == LEN_FMT_7) ? 64'd125 : 64'($urandom_range(126, 300));
		else if (pick < 4)
			len = 64'd0;
		else
			len = 64'($urandom_range(1, 12));
		send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len,
			$urandom(), int'(len));
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		tracker = new();
		phase_idle = '{0, 68, 0, 32};
		phase_stall = '{0, 0, 68, 32};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: header bit extremes, zero-length in the 7-bit and 16-bit
		// forms, 64-bit masked header with a single payload byte
		send_frame(8'h81, 1'b0, LEN_FMT_7, 64'd0, 32'h0, 0);
		send_frame(8'hFF, 1'b1, LEN_FMT_7, 64'd0, 32'hFFFF_FFFF, 0);
		send_frame(8'h72, 1'b0, LEN_FMT_16, 64'd0, 32'h0, 0);
		send_frame(8'h09, 1'b1, LEN_FMT_64, 64'd1, 32'hA55A_0FF0, 1);

		for (int p = 0; p < 4; p++) begin
			src_idle_pct = phase_idle[p];
			sink_stall_pct = phase_stall[p];
			while (words_sent < 250 * (p + 1))
				send_random_frame();
		end
		// Largest length: the frame stays open to the end of the run
		send_frame(8'($urandom_range(0, 255)), 1'b1, LEN_FMT_64, '1, $urandom(), 40);
		s_tvalid <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* websocket_frame_deframer.f */
src/wsd_pkg.sv
src/wsd_core.sv
src/websocket_frame_deframer.sv
sim/tb.sv
